/* src/crs_pkg.sv */
// ----------------------------------------------------------------------------
// crs_pkg: shared types and constants of the rotor substitution block
// command codes, character constants and the wiring control bundle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crs_pkg;

    localparam int CHAR_W = 8;
    localparam int IDX_W  = 5;

    localparam logic [CHAR_W-1:0] LETTER_A = 8'h61;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_FORWARD = 2'd1,
        CMD_REVERSE = 2'd2,
        CMD_ROTATE  = 2'd3
    } t_cmd;

    // control from the sequencer to the wiring column
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [CHAR_W-1:0] wdata;
        logic              rot;
        logic [IDX_W-1:0]  raddr;
    } t_wire_ctl;

endpackage

/* src/cipher_rotor_substitution_top.sv */
// ----------------------------------------------------------------------------
// cipher_rotor_substitution_top: rotor substitution block
// wiring column plus a command sequencer with a shared byte compare
// ----------------------------------------------------------------------------
// usage
//   command channel: drive i_command, i_entry_index and i_letter_in with
//   start high; the beat is taken at a clock edge where busy is low
//   commands: load writes one wiring entry, forward maps a letter through
//   the wiring, reverse searches the wiring, rotate shifts the column
//   result channel: o_valid is high for exactly one cycle with o_letter_out
//   and o_notch; the receiver cannot stall, so every result is final
//   sequence: load, forward and rotate go from accept through the execute
//   state back to idle; reverse then walks the column one entry per cycle
//   through the single compare from entry 0, stopping at the first hit or
//   after the last entry on a miss
//   busy is high from the cycle after accept until the result strobe,
//   so the next beat can be taken in the cycle the strobe shows
//   reset: synchronous, active low; wiring returns to identity (entry i
//   holds 'a'+i), the sequencer idles, and no strobe is pending
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cipher_rotor_substitution_top #(
    parameter int ENTRIES = 26
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // command beat
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_command,
    input  logic [crs_pkg::IDX_W-1:0]  i_entry_index,
    input  logic [crs_pkg::CHAR_W-1:0] i_letter_in,
    // result beat
    output logic                       o_valid,
    output logic [crs_pkg::CHAR_W-1:0] o_letter_out,
    output logic                       o_notch
);

    // control bundle from sequencer to column
    crs_pkg::t_wire_ctl         wire_ctl;
    // combinational read of the selected entry
    logic [crs_pkg::CHAR_W-1:0] rdata;
    // fixed tap on the last entry, used for the rotate notch
    logic [crs_pkg::CHAR_W-1:0] last;

    // sequencer: decodes the beat and scans for reverse lookups
    crs_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_command     (i_command),
        .i_entry_index (i_entry_index),
        .i_letter_in   (i_letter_in),
        .i_rdata       (rdata),
        .i_last        (last),
        .o_ctl         (wire_ctl),
        .o_busy        (busy),
        .o_valid       (o_valid),
        .o_letter_out  (o_letter_out),
        .o_notch       (o_notch)
    );

    // wiring column: write, read and cyclic shift
    crs_wiring #(
        .ENTRIES (ENTRIES)
    ) u_wiring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (wire_ctl),
        .o_rdata (rdata),
        .o_last  (last)
    );

endmodule

/* src/crs_wiring.sv */
// ----------------------------------------------------------------------------
// crs_wiring: rotor wiring column
// register column with one write port, one read port, a last-entry tap and a cyclic shift
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crs_wiring #(
    parameter int ENTRIES = 26
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  crs_pkg::t_wire_ctl        i_ctl,
    output logic [crs_pkg::CHAR_W-1:0] o_rdata,
    output logic [crs_pkg::CHAR_W-1:0] o_last
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [crs_pkg::CHAR_W-1:0] r_wiring [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // identity wiring
            for (int i = 0; i < ENTRIES; i++) begin
                r_wiring[i] <= crs_pkg::CHAR_W'(crs_pkg::LETTER_A + i);
            end
        end else if (i_ctl.rot) begin
            r_wiring[0] <= r_wiring[ENTRIES-1];
            for (int i = 1; i < ENTRIES; i++) begin
                r_wiring[i] <= r_wiring[i-1];
            end
        end else if (i_ctl.we) begin
            r_wiring[i_ctl.waddr[AW-1:0]] <= i_ctl.wdata;
        end
    end

    // out-of-range read address gives zero
    assign o_rdata = (i_ctl.raddr < crs_pkg::IDX_W'(ENTRIES))
                   ? r_wiring[i_ctl.raddr[AW-1:0]] : '0;
    assign o_last  = r_wiring[ENTRIES-1];

endmodule

/* src/crs_ctrl.sv */
// ----------------------------------------------------------------------------
// crs_ctrl: command sequencer with shared byte compare
// decodes one command beat and walks the wiring column for reverse lookups
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crs_ctrl #(
    parameter int ENTRIES = 26
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [1:0]                 i_command,
    input  logic [crs_pkg::IDX_W-1:0]  i_entry_index,
    input  logic [crs_pkg::CHAR_W-1:0] i_letter_in,
    input  logic [crs_pkg::CHAR_W-1:0] i_rdata,
    input  logic [crs_pkg::CHAR_W-1:0] i_last,
    output crs_pkg::t_wire_ctl         o_ctl,
    output logic                       o_busy,
    output logic                       o_valid,
    output logic [crs_pkg::CHAR_W-1:0] o_letter_out,
    output logic                       o_notch
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN
    } t_state;

    t_state                     r_state, n_state;
    crs_pkg::t_cmd              r_cmd, n_cmd;
    logic [crs_pkg::IDX_W-1:0]  r_idx, n_idx;
    logic [crs_pkg::CHAR_W-1:0] r_letter_in, n_letter_in;
    logic [AW-1:0]              r_ptr, n_ptr;
    logic                       r_valid, n_valid;
    logic [crs_pkg::CHAR_W-1:0] r_letter_out, n_letter_out;
    logic                       r_notch, n_notch;

    logic [crs_pkg::CHAR_W-1:0] fwd_diff;
    logic                       fwd_hit;
    logic                       hit;

    assign fwd_diff = r_letter_in - crs_pkg::LETTER_A;
    assign fwd_hit  = (r_letter_in >= crs_pkg::LETTER_A)
                   && (fwd_diff < crs_pkg::CHAR_W'(ENTRIES));
    // shared compare unit
    assign hit      = (i_rdata == r_letter_in);

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_idx        = r_idx;
        n_letter_in  = r_letter_in;
        n_ptr        = r_ptr;
        n_valid      = 1'b0;
        n_letter_out = r_letter_out;
        n_notch      = r_notch;
        o_ctl        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd       = crs_pkg::t_cmd'(i_command);
                    n_idx       = i_entry_index;
                    n_letter_in = i_letter_in;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_cmd)
                    crs_pkg::CMD_LOAD: begin
                        o_ctl.we     = (r_idx < crs_pkg::IDX_W'(ENTRIES));
                        o_ctl.waddr  = r_idx;
                        o_ctl.wdata  = r_letter_in;
                        n_letter_out = r_letter_in;
                        n_notch      = 1'b0;
                        n_valid      = 1'b1;
                        n_state      = S_IDLE;
                    end
                    crs_pkg::CMD_FORWARD: begin
                        o_ctl.raddr  = fwd_diff[crs_pkg::IDX_W-1:0];
                        n_letter_out = fwd_hit ? i_rdata : r_letter_in;
                        n_notch      = 1'b0;
                        n_valid      = 1'b1;
                        n_state      = S_IDLE;
                    end
                    crs_pkg::CMD_REVERSE: begin
                        n_ptr   = '0;
                        n_state = S_SCAN;
                    end
                    crs_pkg::CMD_ROTATE: begin
                        // last entry becomes entry 0
                        o_ctl.rot    = 1'b1;
                        n_notch      = (i_last == crs_pkg::LETTER_A);
                        n_letter_out = '0;
                        n_valid      = 1'b1;
                        n_state      = S_IDLE;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_SCAN: begin
                o_ctl.raddr = crs_pkg::IDX_W'(r_ptr);
                n_notch     = 1'b0;
                if (hit) begin
                    n_letter_out = crs_pkg::LETTER_A + crs_pkg::CHAR_W'(r_ptr);
                    n_valid      = 1'b1;
                    n_state      = S_IDLE;
                end else if (r_ptr == AW'(ENTRIES - 1)) begin
                    n_letter_out = r_letter_in;
                    n_valid      = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_cmd        <= n_cmd;
        r_idx        <= n_idx;
        r_letter_in  <= n_letter_in;
        r_ptr        <= n_ptr;
        r_letter_out <= n_letter_out;
        r_notch      <= n_notch;
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_letter_out = r_letter_out;
    assign o_notch      = r_notch;

    // accepted beat makes the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted beat did not start the sequencer");

    // result strobe only when back to idle, and for one cycle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_busy && !$past(o_valid)))
        else $error("result strobe outside idle or repeated");

    // notch only reported for rotate
    a_notch_rot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_cmd != crs_pkg::CMD_ROTATE) |-> !o_notch)
        else $error("notch set on a non-rotate command");

    // scan pointer stays inside the column
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_ptr <= AW'(ENTRIES - 1)))
        else $error("scan pointer beyond last entry");

    // scan is entered only for reverse commands
    a_scan_rev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_cmd == crs_pkg::CMD_REVERSE))
        else $error("scan running for a non-reverse command");

endmodule
